// ===== rtl/bfha_pkg.sv =====
// Shared constants and the reset image of the best-fit heap allocator.
package bfha_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int HEAP_BYTES = HEAP_WORDS * 4;
   localparam int WORD_AW    = $clog2(HEAP_WORDS);
   localparam int BYTE_W     = $clog2(HEAP_BYTES + 1);

   localparam int REQ_W    = 16;
   localparam int NEED_W   = 17;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 15;

   localparam int HDR_BYTES   = 8;
   localparam int ALIGN_BYTES = 16;
   localparam int FIRST_HDR   = 8;

   localparam logic [31:0] SIZE_MASK     = ~32'd3;
   localparam logic [31:0] END_MARK      = 32'd1;
   localparam logic [31:0] BUSY_BIT      = 32'd1;
   localparam logic [31:0] PREV_BUSY_BIT = 32'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SZ = 2'd2;

   // Layout after reset: one free block at byte 8, its footer, then the end marker.
   localparam int INIT_BLK  = (HEAP_BYTES - 16) & ~(ALIGN_BYTES - 1);
   localparam int HDR_WORD  = FIRST_HDR / 4;
   localparam int FOOT_WORD = (FIRST_HDR + INIT_BLK - HDR_BYTES) / 4;
   localparam int END_WORD  = (FIRST_HDR + INIT_BLK) / 4;

   function automatic logic [31:0] init_word(input logic [WORD_AW-1:0] addr);
      logic [31:0] value;
      value = 32'd0;
      if (addr == WORD_AW'(HDR_WORD)) begin
         value = 32'(INIT_BLK) | PREV_BUSY_BIT;
      end else if (addr == WORD_AW'(FOOT_WORD)) begin
         value = 32'(INIT_BLK);
      end else if (addr == WORD_AW'(END_WORD)) begin
         value = END_MARK;
      end
      return value;
   endfunction

endpackage

// ===== rtl/best_fit_heap_allocator_top.sv =====
// Best-fit heap allocator: header walk over the heap memory and in-place split.
//
// Usage
//   req channel: req_request_size is the payload size in bytes; one response
//   follows every request transfer, in order.
//   rsp channel: rsp_status (0 allocated, 1 nothing fits, 2 zero size) and
//   rsp_payload_offset, the byte offset of the payload (0 unless allocated).
//   Sequence: a zero-size request goes straight to loading its response. Other
//   requests issue the first header read, walk the blocks one by one (the
//   heap memory port delivers one header a cycle and the next address
//   follows from it), make 2 writes for an exact fit or 3 for a split, and
//   then load the response.
//   One request is worked at a time; the next one is taken once the previous
//   one has loaded its response register.
//   Reset: the heap is rebuilt by a pass that writes all HEAP_WORDS words,
//   one per cycle; req_ready stays low meanwhile.
//   Stall: a response waits in its register while rsp_ready is low; the next
//   request is still taken and walked, and holds before loading its
//   response until the register is free.
module best_fit_heap_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bfha_pkg::REQ_W-1:0]      req_request_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bfha_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bfha_pkg::OFFSET_W-1:0]   rsp_payload_offset
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_WRA  = 3'd3;
   localparam logic [2:0] ST_WRB  = 3'd4;
   localparam logic [2:0] ST_WRC  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam int AW = bfha_pkg::WORD_AW;
   localparam int BW = bfha_pkg::BYTE_W;

   logic [31:0] heap_mem [bfha_pkg::HEAP_WORDS];
   logic [31:0] mem_rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_we;

   logic [2:0]  state_ff, state_in;
   logic [AW-1:0] init_addr_ff, init_addr_in;
   logic [bfha_pkg::NEED_W-1:0] need_ff, need_in;
   logic [BW-1:0] b_ff, b_in;
   logic          found_ff, found_in;
   logic [BW-1:0] best_ff, best_in;
   logic [BW-1:0] best_sz_ff, best_sz_in;
   logic [31:0]   best_hdr_ff, best_hdr_in;
   logic [bfha_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [bfha_pkg::OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [bfha_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bfha_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic [bfha_pkg::NEED_W-1:0] need_calc;
   logic [31:0] hdr, sz, room, next_b, wr_byte, foot, rem, off_sum;
   logic        stop_here, take, past_end, walk_end, split, rsp_load;

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;

   // Header plus payload, rounded up to the alignment.
   assign need_calc = (bfha_pkg::NEED_W'(req_request_size)
                       + bfha_pkg::NEED_W'(bfha_pkg::HDR_BYTES + bfha_pkg::ALIGN_BYTES - 1))
                      & ~bfha_pkg::NEED_W'(bfha_pkg::ALIGN_BYTES - 1);

   // Header evaluation for the word read in the previous cycle.
   assign hdr       = mem_rdata_ff;
   assign sz        = hdr & bfha_pkg::SIZE_MASK;
   assign room      = 32'(bfha_pkg::HEAP_BYTES) - 32'(b_ff);
   assign stop_here = (hdr == bfha_pkg::END_MARK) || (sz == 32'd0) || (sz > room);
   assign take      = !stop_here && !hdr[0] && (sz >= 32'(need_ff))
                      && (!found_ff || (sz < 32'(best_sz_ff)));
   assign next_b    = 32'(b_ff) + sz;
   assign past_end  = next_b > 32'(bfha_pkg::HEAP_BYTES - 4);
   assign walk_end  = stop_here || past_end;

   // Allocation arithmetic on the chosen block.
   assign split   = 32'(best_sz_ff) > 32'(need_ff);
   assign foot    = 32'(best_ff) + 32'(best_sz_ff) - 32'(bfha_pkg::HDR_BYTES);
   assign rem     = 32'(best_sz_ff) - 32'(need_ff) + bfha_pkg::PREV_BUSY_BIT;
   assign off_sum = 32'(best_ff) + 32'(bfha_pkg::HDR_BYTES);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mem_raddr = AW'(bfha_pkg::HDR_WORD);
      if (state_ff == ST_WALK) begin
         mem_raddr = next_b[AW+1:2];
      end
   end

   always_comb begin
      wr_byte   = 32'(best_ff);
      mem_wdata = 32'd0;
      case (state_ff)
         ST_WRA: begin
            if (split) begin
               wr_byte   = 32'(best_ff) + 32'(need_ff);
               mem_wdata = rem;
            end else begin
               wr_byte   = 32'(best_ff);
               mem_wdata = best_hdr_ff + bfha_pkg::BUSY_BIT;
            end
         end
         ST_WRB: begin
            wr_byte   = foot;
            mem_wdata = split ? rem : 32'd0;
         end
         ST_WRC: begin
            wr_byte   = 32'(best_ff);
            mem_wdata = (best_hdr_ff & bfha_pkg::PREV_BUSY_BIT) + 32'(need_ff)
                        + bfha_pkg::BUSY_BIT;
         end
         default: begin
            wr_byte   = 32'(best_ff);
            mem_wdata = 32'd0;
         end
      endcase
      mem_we    = 1'b0;
      mem_waddr = wr_byte[AW+1:2];
      if (state_ff == ST_INIT) begin
         mem_we    = 1'b1;
         mem_waddr = init_addr_ff;
         mem_wdata = bfha_pkg::init_word(init_addr_ff);
      end else if (state_ff == ST_WRA || state_ff == ST_WRB || state_ff == ST_WRC) begin
         // drop writes that fall beyond the heap
         mem_we = wr_byte < 32'(bfha_pkg::HEAP_BYTES);
      end
   end

   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      need_in       = need_ff;
      b_in          = b_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_sz_in    = best_sz_ff;
      best_hdr_in   = best_hdr_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      case (state_ff)
         ST_INIT: begin
            init_addr_in = init_addr_ff + AW'(1);
            if (init_addr_ff == AW'(bfha_pkg::HEAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_offset_in = '0;
               if (req_request_size == '0) begin
                  res_status_in = bfha_pkg::STATUS_ZERO_SZ;
                  state_in      = ST_DONE;
               end else begin
                  need_in  = need_calc;
                  b_in     = BW'(bfha_pkg::FIRST_HDR);
                  found_in = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (take) begin
               found_in    = 1'b1;
               best_in     = b_ff;
               best_sz_in  = sz[BW-1:0];
               best_hdr_in = hdr;
            end
            b_in = next_b[BW-1:0];
            if (walk_end) begin
               if (found_ff || take) begin
                  state_in = ST_WRA;
               end else begin
                  res_status_in = bfha_pkg::STATUS_NO_FIT;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_WRA: begin
            state_in = ST_WRB;
         end
         ST_WRB: begin
            res_status_in = bfha_pkg::STATUS_OK;
            res_offset_in = off_sum[bfha_pkg::OFFSET_W-1:0];
            state_in      = split ? ST_WRC : ST_DONE;
         end
         ST_WRC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_offset_in = res_offset_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= heap_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      b_ff          <= b_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_sz_ff    <= best_sz_in;
      best_hdr_ff   <= best_hdr_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // The heap is never written while headers are being walked.
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !mem_we)
      else $error("heap write during header walk");

   // A response appears only after the result has been loaded from DONE.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside DONE");

   // Payloads sit on the alignment boundary.
   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bfha_pkg::STATUS_OK) |-> (rsp_offset_ff[3:0] == 4'd0))
      else $error("misaligned payload offset");

   // The walk pointer stays inside the heap.
   a_walk_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (32'(b_ff) <= 32'(bfha_pkg::HEAP_BYTES - 4)))
      else $error("walk pointer beyond heap");

endmodule

// ===== bench/tb_best_fit_heap_allocator_top.sv =====
// Self-checking testbench for the best-fit heap allocator, with its own heap image.
`timescale 1ns / 100ps

typedef struct packed {
   logic [bfha_pkg::STATUS_W-1:0] status;
   logic [bfha_pkg::OFFSET_W-1:0] offset;
} alloc_result_type;

class heap_scoreboard;
   logic [31:0]      heap_image [bfha_pkg::HEAP_WORDS];
   alloc_result_type awaited[$];
   int unsigned      free_left;
   int               errors;

   function new();
      foreach (heap_image[i]) heap_image[i] = '0;
      put_word(bfha_pkg::FIRST_HDR, bfha_pkg::INIT_BLK | bfha_pkg::PREV_BUSY_BIT);
      put_word(bfha_pkg::FIRST_HDR + bfha_pkg::INIT_BLK - bfha_pkg::HDR_BYTES,
               bfha_pkg::INIT_BLK);
      put_word(bfha_pkg::FIRST_HDR + bfha_pkg::INIT_BLK, bfha_pkg::END_MARK);
      free_left = bfha_pkg::INIT_BLK;
      errors = 0;
   endfunction

   function logic [31:0] get_word(int unsigned byte_off);
      return (byte_off / 4 < bfha_pkg::HEAP_WORDS) ? heap_image[byte_off / 4] : 32'd0;
   endfunction

   function void put_word(int unsigned byte_off, logic [31:0] value);
      if (byte_off / 4 < bfha_pkg::HEAP_WORDS) heap_image[byte_off / 4] = value;
   endfunction

   // Walk the block list, allocate in the image and queue the expected response.
   function void note_request(logic [bfha_pkg::REQ_W-1:0] size);
      int unsigned      need, pos, hdr, blk, best, best_sz, foot, rest;
      bit               found, walking;
      alloc_result_type res;
      res.status = bfha_pkg::STATUS_OK;
      res.offset = '0;
      found = 1'b0;
      best = 0;
      best_sz = 0;
      if (size == '0) begin
         res.status = bfha_pkg::STATUS_ZERO_SZ;
      end else begin
         need = ((32'(size) + bfha_pkg::HDR_BYTES + bfha_pkg::ALIGN_BYTES - 1)
                 / bfha_pkg::ALIGN_BYTES) * bfha_pkg::ALIGN_BYTES;
         pos = bfha_pkg::FIRST_HDR;
         walking = 1'b1;
         while (walking) begin
            if (pos + 4 > bfha_pkg::HEAP_BYTES) begin
               walking = 1'b0;
            end else begin
               hdr = get_word(pos);
               blk = hdr & bfha_pkg::SIZE_MASK;
               // a zero size or a block past the heap end stops the walk like the marker
               if (hdr == bfha_pkg::END_MARK || blk == 0
                   || blk > bfha_pkg::HEAP_BYTES - pos) begin
                  walking = 1'b0;
               end else begin
                  if ((hdr & bfha_pkg::BUSY_BIT) == 0 && blk >= need
                      && (!found || blk < best_sz)) begin
                     found = 1'b1;
                     best = pos;
                     best_sz = blk;
                  end
                  pos += blk;
               end
            end
         end
         if (!found) begin
            res.status = bfha_pkg::STATUS_NO_FIT;
         end else begin
            hdr = get_word(best);
            foot = best + best_sz - bfha_pkg::HDR_BYTES;
            if (best_sz > need) begin
               rest = best_sz - need + bfha_pkg::PREV_BUSY_BIT;
               put_word(best + need, rest);
               put_word(foot, rest);
               put_word(best, (hdr & bfha_pkg::PREV_BUSY_BIT) + need + bfha_pkg::BUSY_BIT);
               free_left -= need;
            end else begin
               // exact fit: the following header keeps its previous-busy bit
               put_word(best, hdr + bfha_pkg::BUSY_BIT);
               put_word(foot, 32'd0);
               free_left -= best_sz;
            end
            res.offset = bfha_pkg::OFFSET_W'(best + bfha_pkg::HDR_BYTES);
         end
      end
      awaited.push_back(res);
   endfunction

   function void check_response(logic [bfha_pkg::STATUS_W-1:0] status,
                                logic [bfha_pkg::OFFSET_W-1:0] offset);
      alloc_result_type want;
      if (awaited.size() == 0) begin
         $display("%0t: response with none awaited: expected nothing, got status %0d offset %0d",
                  $time, status, offset);
         errors++;
      end else begin
         want = awaited.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
            errors++;
         end
         if (offset !== want.offset) begin
            $display("%0t: payload offset mismatch: expected %0d, got %0d",
                     $time, want.offset, offset);
            errors++;
         end
      end
   endfunction
endclass

module tb_best_fit_heap_allocator_top;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [bfha_pkg::REQ_W-1:0]    req_request_size = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bfha_pkg::STATUS_W-1:0] rsp_status;
   logic [bfha_pkg::OFFSET_W-1:0] rsp_payload_offset;

   int unsigned    send_idle_pct = 0;
   int unsigned    rsp_stall_pct = 0;
   heap_scoreboard sb = new();

   logic [bfha_pkg::REQ_W-1:0] opening_sizes [13] = '{
      16'd0, 16'hFFFF, 16'h8000, 16'd16361, 16'd1, 16'd8, 16'd9,
      16'd24, 16'd25, 16'h4000, 16'd1000, 16'd0, 16'd2
   };

   best_fit_heap_allocator_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_request_size   (req_request_size),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_status, rsp_payload_offset);
      end
   end

   // Hold valid and payload until the transfer, then record it.
   task automatic send_request(input logic [bfha_pkg::REQ_W-1:0] size);
      if (send_idle_pct != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_request_size <= size;
      do @(posedge clock); while (!req_ready);
      sb.note_request(size);
   endtask

   function automatic logic [bfha_pkg::REQ_W-1:0] pick_size();
      int unsigned roll, left, lo;
      roll = $urandom_range(99);
      left = sb.free_left;
      if (roll < 10) return '0;
      if (roll < 30) return bfha_pkg::REQ_W'($urandom_range(65535, 16384));
      if (roll < 66) begin
         // straddle what is left; while plenty remains, stay on the too-large side
         if (left > 1024) return bfha_pkg::REQ_W'($urandom_range(left + 40, left - 7));
         lo = (left > 41) ? left - 40 : 1;
         return bfha_pkg::REQ_W'($urandom_range(left + 24, lo));
      end
      if (roll < 70) return bfha_pkg::REQ_W'($urandom_range(160, 49));
      return bfha_pkg::REQ_W'($urandom_range(48, 1));
   endfunction

   initial begin
      int unsigned phase, n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_sizes[i]) send_request(opening_sizes[i]);
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 81;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 81;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase
         for (n = 0; n < 447; n++) send_request(pick_size());
      end
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      // allow for a walk over a fully split heap
      repeat (1100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
